@@ design/otq_pkg.sv @@
// ----------------------------------------------------------------------------
// otq_pkg: shared types and constants of the ordered timer queue
// Slot entry layout, request and response words, function and result codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package otq_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int TIME_BITS   = 48;
	localparam int MAX_RESULTS = 16;

	localparam int SLOT_W = $clog2(TIMER_SLOTS);
	localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
	localparam int POP_W  = $clog2(MAX_RESULTS + 1);

	localparam int ID_W   = 32;
	localparam int TAG_W  = 16;
	localparam int DUR_W  = 24;
	localparam int KIND_W = 3;
	localparam int ACT_W  = 5;

	// request function codes
	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_ADJUST = 2'd2;
	localparam logic [1:0] FUNC_TICK   = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ADJUST  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NO_DUE  = 3'd4;

	// cell operations, broadcast to the whole row
	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_DELETE = 2'd2;
	localparam logic [1:0] CELL_POP    = 2'd3;

	typedef struct packed {
		logic [TIME_BITS-1:0] expiry;
		logic [ID_W-1:0]      id;
		logic [TAG_W-1:0]     tag;
	} entry_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [ID_W-1:0]  timer_id;
		logic [DUR_W-1:0] duration;
		logic [TAG_W-1:0] callback_tag;
	} timer_req_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic              ok;
		logic [ID_W-1:0]   result_id;
		logic [TAG_W-1:0]  result_tag;
		logic [ACT_W-1:0]  active_count;
		logic              last;
	} timer_rsp_t;

	// command seen by every cell
	typedef struct packed {
		logic [1:0] op;
		entry_t     key;
	} cell_cmd_t;

	// flags a cell hands to its right-hand neighbour
	typedef struct packed {
		logic le;    // occupied and expiry not later than the key
		logic seen;  // id match at this cell or any cell to the left
	} cell_link_t;

endpackage

@@ design/otq_cell.sv @@
// ----------------------------------------------------------------------------
// otq_cell: one slot of the sorted timer row
// Holds one entry; shifts right on insert, left on delete or pop, and
// compares its expiry and id against the broadcast key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otq_cell
	import otq_pkg::*;
(
	input  logic       clk,
	input  cell_cmd_t  cmd,
	input  logic       occupied,
	input  cell_link_t left_link,
	input  entry_t     left_ent,
	input  entry_t     right_ent,
	output cell_link_t link,
	output logic       first_hit,
	output entry_t     ent
);

	entry_t ent_q;
	logic   match;

	assign ent = ent_q;

	// compare against the broadcast key
	assign match          = occupied && (ent_q.id == cmd.key.id);
	assign link.le        = occupied && (ent_q.expiry <= cmd.key.expiry);
	assign link.seen      = left_link.seen | match;
	assign first_hit      = match & ~left_link.seen;

	// slot update
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_INSERT: begin
				if (!link.le) begin
					ent_q <= left_link.le ? cmd.key : left_ent;
				end
			end
			CELL_DELETE: begin
				if (link.seen) begin
					ent_q <= right_ent;
				end
			end
			CELL_POP: begin
				ent_q <= right_ent;
			end
			default: begin
				ent_q <= ent_q;
			end
		endcase
	end

endmodule

@@ design/ordered_timer_queue.sv @@
// ----------------------------------------------------------------------------
// ordered_timer_queue: sorted queue of one-shot timers
// Timers sit in a row of slot cells in expiry order, ties in insertion
// order. An add is accepted, then inserted across the row if its tag is
// nonzero and a slot is free; a remove is accepted, then searched for and,
// if found, the gap closed; an adjust is accepted, removed and, if found,
// reinserted; a tick gives one result word per expired timer, since the
// head cell is popped once per word, or a single no-due word when nothing
// has expired. Every result word waits in an output register; further
// work is held while that register is full and not taken. The slot row has
// no clearing pass: the pending count marks which cells hold timers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_timer_queue
	import otq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  timer_req_t in_word,
	output logic       out_valid,
	input  logic       out_ready,
	output timer_rsp_t out_word
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ADD   = 3'd1;
	localparam logic [2:0] ST_FIND  = 3'd2;
	localparam logic [2:0] ST_REINS = 3'd3;
	localparam logic [2:0] ST_POP   = 3'd4;

	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	logic [2:0]           state_q;
	timer_req_t           req_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ID_W-1:0]      next_id_q;
	logic [TIME_BITS-1:0] time_q;
	logic [TAG_W-1:0]     adj_tag_q;
	logic [POP_W-1:0]     pop_n_q;
	logic                 out_valid_q;
	timer_rsp_t           out_word_q;

	cell_cmd_t            cmd;
	logic                 occ     [TIMER_SLOTS];
	entry_t               ent_w   [TIMER_SLOTS];
	cell_link_t           link_w  [TIMER_SLOTS];
	cell_link_t           lnk_in  [TIMER_SLOTS];
	entry_t               lent_w  [TIMER_SLOTS];
	entry_t               rent_w  [TIMER_SLOTS];
	logic                 hit_w   [TIMER_SLOTS];

	logic                 out_free;
	logic                 found;
	logic [TAG_W-1:0]     found_tag;
	logic [TIME_BITS:0]   exp_sum;
	logic [TIME_BITS-1:0] exp_new;
	logic                 head_due;
	logic                 second_due;
	logic [ID_W-1:0]      id_inc;

	logic [2:0]           state_d;
	logic [CNT_W-1:0]     cnt_d;
	logic                 emit;
	timer_rsp_t           rsp;

	// function code to result kind
	function automatic logic [KIND_W-1:0] KIND_KIND(input logic [1:0] f);
		KIND_KIND = (f == FUNC_REMOVE) ? KIND_REMOVE : KIND_ADJUST;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_free  = !out_valid_q || out_ready;

	// saturating expiry for add and adjust
	assign exp_sum = {1'b0, time_q} + {{(TIME_BITS + 1 - DUR_W){1'b0}}, req_q.duration};
	assign exp_new = exp_sum[TIME_BITS] ? TIME_MAX : exp_sum[TIME_BITS-1:0];

	// next id skips zero on wrap
	assign id_inc = (next_id_q + 1'b1 == '0) ? ID_W'(1) : next_id_q + 1'b1;

	// row of slot cells
	for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < cnt_q);
		if (i == 0) begin : g_first
			assign lnk_in[i] = '{le: 1'b1, seen: 1'b0};
			assign lent_w[i] = cmd.key;
		end else begin : g_mid
			assign lnk_in[i] = link_w[i-1];
			assign lent_w[i] = ent_w[i-1];
		end
		if (i == TIMER_SLOTS - 1) begin : g_last
			assign rent_w[i] = ent_w[i];
		end else begin : g_inner
			assign rent_w[i] = ent_w[i+1];
		end
		otq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occupied  (occ[i]),
			.left_link (lnk_in[i]),
			.left_ent  (lent_w[i]),
			.right_ent (rent_w[i]),
			.link      (link_w[i]),
			.first_hit (hit_w[i]),
			.ent       (ent_w[i])
		);
	end

	assign found      = link_w[TIMER_SLOTS-1].seen;
	assign head_due   = occ[0] && (ent_w[0].expiry <= time_q);
	assign second_due = occ[1] && (ent_w[1].expiry <= time_q);

	// tag of the first matching slot
	always_comb begin
		found_tag = '0;
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			found_tag = found_tag | (hit_w[i] ? ent_w[i].tag : '0);
		end
	end

	// sequencer
	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		emit           = 1'b0;
		cmd.op         = CELL_HOLD;
		cmd.key.expiry = exp_new;
		cmd.key.id     = req_q.timer_id;
		cmd.key.tag    = req_q.callback_tag;
		rsp            = '0;
		rsp.last       = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (in_word.func)
						FUNC_ADD:                 state_d = ST_ADD;
						FUNC_REMOVE, FUNC_ADJUST: state_d = ST_FIND;
						default:                  state_d = ST_POP;
					endcase
				end
			end
			ST_ADD: begin
				cmd.key.id = next_id_q;
				if (out_free) begin
					emit             = 1'b1;
					rsp.result_kind  = KIND_ADD;
					state_d          = ST_IDLE;
					if (req_q.callback_tag != '0 && cnt_q != CNT_W'(TIMER_SLOTS)) begin
						cmd.op        = CELL_INSERT;
						cnt_d         = cnt_q + 1'b1;
						rsp.ok        = 1'b1;
						rsp.result_id = next_id_q;
					end
				end
			end
			ST_FIND: begin
				if (out_free) begin
					rsp.result_kind = KIND_KIND(req_q.func);
					rsp.result_id   = req_q.timer_id;
					if (!found) begin
						emit    = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.op = CELL_DELETE;
						cnt_d  = cnt_q - 1'b1;
						if (req_q.func == FUNC_REMOVE) begin
							emit    = 1'b1;
							rsp.ok  = 1'b1;
							state_d = ST_IDLE;
						end else begin
							state_d = ST_REINS;
						end
					end
				end
			end
			ST_REINS: begin
				cmd.key.tag = adj_tag_q;
				if (out_free) begin
					cmd.op          = CELL_INSERT;
					cnt_d           = cnt_q + 1'b1;
					emit            = 1'b1;
					rsp.result_kind = KIND_ADJUST;
					rsp.ok          = 1'b1;
					rsp.result_id   = req_q.timer_id;
					state_d         = ST_IDLE;
				end
			end
			ST_POP: begin
				if (out_free) begin
					emit   = 1'b1;
					rsp.ok = 1'b1;
					if (head_due && pop_n_q != POP_W'(MAX_RESULTS)) begin
						cmd.op          = CELL_POP;
						cnt_d           = cnt_q - 1'b1;
						rsp.result_kind = KIND_EXPIRED;
						rsp.result_id   = ent_w[0].id;
						rsp.result_tag  = ent_w[0].tag;
						rsp.last        = !second_due ||
							(pop_n_q == POP_W'(MAX_RESULTS - 1));
						if (rsp.last) begin
							state_d = ST_IDLE;
						end
					end else begin
						rsp.result_kind = KIND_NO_DUE;
						state_d         = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		rsp.active_count = ACT_W'(cnt_d);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			next_id_q   <= ID_W'(1);
			time_q      <= '0;
			pop_n_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == ST_IDLE && in_valid && in_word.func == FUNC_TICK &&
				time_q != TIME_MAX) begin
				time_q <= time_q + 1'b1;
			end
			if (state_q == ST_ADD && cmd.op == CELL_INSERT) begin
				next_id_q <= id_inc;
			end
			if (state_q == ST_IDLE) begin
				pop_n_q <= '0;
			end else if (cmd.op == CELL_POP) begin
				pop_n_q <= pop_n_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_word;
		end
		if (state_q == ST_FIND) begin
			adj_tag_q <= found_tag;
		end
		if (emit) begin
			out_word_q <= rsp;
		end
	end

endmodule
